// ===== design/lphm_pkg.sv =====
`default_nettype none
package lphm_pkg;

  // Operation codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_GET   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // Partial-product selects for the 64x64 low-half multiply
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LL   = 2'd1;
  localparam logic [1:0] MUL_HL   = 2'd2;
  localparam logic [1:0] MUL_LH   = 2'd3;

  // Finalizer multipliers
  localparam logic [63:0] FMIX_C0 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C1 = 64'hc4ceb9fe1a85ec53;

  // Load limit handling
  localparam logic [3:0] LIM_RESET = 4'd7;
  localparam logic [3:0] LIM_MAX   = 4'd9;

  // Config register index
  localparam logic REG_LOAD_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic        inserted_new;
    logic [10:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic [1:0] mul_part;
    logic       mul_c1;
    logic       fold;
    logic       probe_start;
    logic       probe_next;
    logic       mem_rd;
    logic       mem_put;
    logic       sweep;
    logic       count_inc;
    logic       count_clr;
    logic       out_load;
    logic [1:0] res_status;
    logic       res_ins;
    logic       res_hit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       used;
    logic       match;
    logic       sweep_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== design/lphm_ctrl.sv =====
`default_nettype none
module lphm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lphm_pkg::sts_t sts,
  output lphm_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_RSTCLR = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_CMP    = 3'd5;
  localparam logic [2:0] S_CLR    = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_ins_r, res_ins_nxt;
  logic       res_hit_r, res_hit_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequence one item at a time
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    res_status_nxt = res_status_r;
    res_ins_nxt    = res_ins_r;
    res_hit_nxt    = res_hit_r;
    cmd            = '0;
    cmd.res_status = res_status_r;
    cmd.res_ins    = res_ins_r;
    cmd.res_hit    = res_hit_r;
    case (state_r)
      S_RSTCLR: begin
        cmd.sweep     = 1'b1;
        cmd.count_clr = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          res_status_nxt = lphm_pkg::ST_OK;
          res_ins_nxt    = 1'b0;
          res_hit_nxt    = 1'b0;
          step_nxt       = 3'd0;
          state_nxt      = S_HASH;
        end
      end
      S_HASH: begin
        // Dispatch on the latched action before spending hash cycles
        if (sts.action == lphm_pkg::ACT_CLEAR) begin
          state_nxt = S_CLR;
        end else if (sts.action != lphm_pkg::ACT_PUT && sts.action != lphm_pkg::ACT_GET) begin
          state_nxt = S_RESP;
        end else begin
          cmd.mul_c1 = step_r[2];
          case (step_r[1:0])
            2'd0:    cmd.mul_part = lphm_pkg::MUL_LL;
            2'd1:    cmd.mul_part = lphm_pkg::MUL_HL;
            2'd2:    cmd.mul_part = lphm_pkg::MUL_LH;
            default: cmd.fold = 1'b1;
          endcase
          step_nxt = step_r + 3'd1;
          if (step_r == 3'd7) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.probe_start = 1'b1;
        if (sts.action == lphm_pkg::ACT_PUT && sts.full) begin
          res_status_nxt = lphm_pkg::ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        if (!sts.used) begin
          if (sts.action == lphm_pkg::ACT_PUT) begin
            cmd.mem_put   = 1'b1;
            cmd.count_inc = 1'b1;
            res_ins_nxt   = 1'b1;
          end else begin
            res_status_nxt = lphm_pkg::ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end else if (sts.match) begin
          if (sts.action == lphm_pkg::ACT_PUT) cmd.mem_put = 1'b1;
          else res_hit_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_CLR: begin
        cmd.sweep     = 1'b1;
        cmd.count_clr = 1'b1;
        if (sts.sweep_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_RSTCLR;
      step_r       <= 3'd0;
      res_status_r <= lphm_pkg::ST_OK;
      res_ins_r    <= 1'b0;
      res_hit_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      res_status_r <= res_status_nxt;
      res_ins_r    <= res_ins_nxt;
      res_hit_r    <= res_hit_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/lphm_dp.sv =====
`default_nettype none
module lphm_dp #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lphm_pkg::in_item_t   in_data,
  input  wire logic [3:0]           load_limit,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output lphm_pkg::out_item_t       out_data,
  input  wire lphm_pkg::cmd_t       cmd,
  output lphm_pkg::sts_t            sts
);

  localparam int IW  = $clog2(ENTRIES);
  localparam int CW  = IW + 1;
  localparam int FW  = CW + 4;
  localparam int ROW = 129;

  logic [1:0]    action_r;
  logic [63:0]   key_r, value_r;
  logic [63:0]   h_r, acc_r;
  logic [IW-1:0] probe_r, sweep_r;
  logic [CW-1:0] count_r;
  logic [ROW-1:0] rdata_r;
  logic          out_valid_r;
  lphm_pkg::out_item_t out_data_r;

  logic [ROW-1:0] mem [ENTRIES];

  logic [31:0]   op_a, op_b;
  logic [63:0]   prod, cst;
  logic [3:0]    lim_sat;
  logic [FW-1:0] need, cap;
  logic [IW-1:0] waddr;
  logic [ROW-1:0] wrow;
  logic          we;

  // Partial product of the low-half 64x64 multiply
  assign cst  = cmd.mul_c1 ? lphm_pkg::FMIX_C1 : lphm_pkg::FMIX_C0;
  assign op_a = (cmd.mul_part == lphm_pkg::MUL_HL) ? h_r[63:32] : h_r[31:0];
  assign op_b = (cmd.mul_part == lphm_pkg::MUL_LH) ? cst[63:32] : cst[31:0];
  assign prod = 64'(op_a) * 64'(op_b);

  // Fill check
  assign lim_sat = (load_limit > lphm_pkg::LIM_MAX) ? lphm_pkg::LIM_MAX : load_limit;
  assign need    = (FW'(count_r) + FW'(1)) * FW'(10);
  assign cap     = FW'(ENTRIES) * FW'(lim_sat);

  assign sts.action     = action_r;
  assign sts.full       = (need >= cap);
  assign sts.used       = rdata_r[ROW-1];
  assign sts.match      = (rdata_r[127:64] == key_r);
  assign sts.sweep_last = (sweep_r == {IW{1'b1}});
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Hold item, hash and probe position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_data.action;
      key_r    <= in_data.key;
      value_r  <= in_data.value;
      h_r      <= in_data.key ^ (in_data.key >> 33);
    end else if (cmd.fold) begin
      h_r <= acc_r ^ (acc_r >> 33);
    end
    case (cmd.mul_part)
      lphm_pkg::MUL_LL: acc_r <= prod;
      lphm_pkg::MUL_HL,
      lphm_pkg::MUL_LH: acc_r <= acc_r + {prod[31:0], 32'b0};
      default:          acc_r <= acc_r;
    endcase
    if (cmd.probe_start)     probe_r <= h_r[IW-1:0];
    else if (cmd.probe_next) probe_r <= probe_r + IW'(1);
  end

  // Slot table: used flag, key, value per row
  assign we    = cmd.sweep || cmd.mem_put;
  assign waddr = cmd.sweep ? sweep_r : probe_r;
  assign wrow  = cmd.sweep ? '0 : {1'b1, key_r, value_r};

  always_ff @(posedge clk) begin
    if (we)         mem[waddr] <= wrow;
    if (cmd.mem_rd) rdata_r <= mem[probe_r];
  end

  // Advance sweep pointer and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      count_r <= '0;
    end else begin
      if (cmd.sweep) sweep_r <= sweep_r + IW'(1);
      if (cmd.count_clr)      count_r <= '0;
      else if (cmd.count_inc) count_r <= count_r + CW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status       <= cmd.res_status;
      out_data_r.read_value   <= cmd.res_hit ? rdata_r[63:0] : 64'd0;
      out_data_r.inserted_new <= cmd.res_ins;
      out_data_r.entry_count  <= 11'(count_r);
    end
  end

endmodule
`default_nettype wire

// ===== design/linear_probe_hash_map.sv =====
`default_nettype none
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   lphm_pkg::in_item_t  (action, key, value)
// out_      output     out_valid/out_stall lphm_pkg::out_item_t (status, read_value,
//                                          inserted_new, entry_count)
// cfg_      input      APB, pready high    load_limit_tenths at byte address 0
//
// A put or get probes the single-port slot table one slot at a time, reading a
// row and then comparing it. Each finalizer round builds the 64x64 low-half
// multiply from partial products LL, HL and LH, then folds. A put refused as full
// responds after the hash without probing; action 3 skips the hash. A clear sweeps
// the table one slot per cycle; after reset the same sweep runs with in_stall high.
// The next item is taken while a result waits under out_stall.
module linear_probe_hash_map #(
  parameter int ENTRIES = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lphm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lphm_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  lphm_pkg::cmd_t cmd;
  lphm_pkg::sts_t sts;
  logic [3:0]     load_limit_r;

  // Config register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == lphm_pkg::REG_LOAD_LIMIT) ? 32'(load_limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= lphm_pkg::LIM_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == lphm_pkg::REG_LOAD_LIMIT) begin
      load_limit_r <= cfg_pwdata[3:0];
    end
  end

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lphm_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .load_limit (load_limit_r),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire
